// ----- rtl/tmpm_pkg.sv -----
// shared types and constants of the trie multi-pattern matcher
// used by the chain, the top level and the checker, depends on nothing
package tmpm_pkg;

    localparam int NODES_DEF     = 1024;
    localparam int MAX_DEPTH_DEF = 16;
    localparam int ALPHABET_DEF  = 26;
    localparam int POS_BITS_DEF  = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int LETTER_W      = 5;
    localparam int POS_OUT_W     = 16;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_MATCH   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_UPD,
        ST_LOAD_OUT,
        ST_WALK,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_DEAD,
        SRC_CELL,
        SRC_ROOT
    } t_a_src;

    typedef struct packed {
        logic   shift;
        logic   rotate;
        logic   clear;
        logic   letter_ok;
        t_a_src a_src;
    } t_chain_ctl;

endpackage

// ----- rtl/tmpm_cell.sv -----
// one walk cell: live flag, match flag, trie node and start position
// does not use tmpm_pkg and depends on nothing
module tmpm_cell #(
    parameter int NODE_W = 10,
    parameter int POS_W  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_load,
    input  logic              i_live,
    input  logic              i_match,
    input  logic [NODE_W-1:0] i_node,
    input  logic [POS_W-1:0]  i_start,
    output logic              o_live,
    output logic              o_match,
    output logic [NODE_W-1:0] o_node,
    output logic [POS_W-1:0]  o_start
);

    logic              r_live;
    logic              r_match;
    logic [NODE_W-1:0] r_node;
    logic [POS_W-1:0]  r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_match <= 1'b0;
        end else if (i_clear) begin
            r_live  <= 1'b0;
            r_match <= 1'b0;
        end else if (i_load) begin
            r_live  <= i_live;
            r_match <= i_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_node  <= i_node;
            r_start <= i_start;
        end
    end

    assign o_live  = r_live;
    assign o_match = r_match;
    assign o_node  = r_node;
    assign o_start = r_start;

endmodule

// ----- rtl/tmpm_walk_chain.sv -----
// row of walk cells, oldest at the head, plus child and mark lookup stages
// depends on tmpm_pkg and tmpm_cell
module tmpm_walk_chain #(
    parameter int NODE_W = 10,
    parameter int POS_W  = 16,
    parameter int DEPTH  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmpm_pkg::t_chain_ctl i_ctl,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [NODE_W-1:0]    i_child,
    input  logic                 i_mark,
    output logic [NODE_W-1:0]    o_rd_node,
    output logic [NODE_W-1:0]    o_mark_node,
    output logic                 o_push_match,
    output logic                 o_head_match,
    output logic [POS_W-1:0]     o_head_start
);

    logic              w_live  [DEPTH];
    logic              w_match [DEPTH];
    logic [NODE_W-1:0] w_node  [DEPTH];
    logic [POS_W-1:0]  w_start [DEPTH];

    logic              r_a_live;
    logic [POS_W-1:0]  r_a_start;
    logic              r_b_live;
    logic [NODE_W-1:0] r_b_node;
    logic [POS_W-1:0]  r_b_start;

    logic              w_tail_live;
    logic              w_tail_match;
    logic [NODE_W-1:0] w_tail_node;
    logic [POS_W-1:0]  w_tail_start;
    logic              w_load;

    assign w_load       = i_ctl.shift | i_ctl.rotate;
    assign o_push_match = r_b_live & i_mark;

    always_comb begin
        if (i_ctl.rotate) begin
            w_tail_live  = w_live[0];
            w_tail_match = w_match[0];
            w_tail_node  = w_node[0];
            w_tail_start = w_start[0];
        end else begin
            w_tail_live  = r_b_live;
            w_tail_match = o_push_match;
            w_tail_node  = r_b_node;
            w_tail_start = r_b_start;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == DEPTH - 1) begin : g_tail
                tmpm_cell #(.NODE_W(NODE_W), .POS_W(POS_W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_clear (i_ctl.clear),
                    .i_load  (w_load),
                    .i_live  (w_tail_live),
                    .i_match (w_tail_match),
                    .i_node  (w_tail_node),
                    .i_start (w_tail_start),
                    .o_live  (w_live[gi]),
                    .o_match (w_match[gi]),
                    .o_node  (w_node[gi]),
                    .o_start (w_start[gi])
                );
            end else begin : g_body
                tmpm_cell #(.NODE_W(NODE_W), .POS_W(POS_W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_clear (i_ctl.clear),
                    .i_load  (w_load),
                    .i_live  (w_live[gi+1]),
                    .i_match (w_match[gi+1]),
                    .i_node  (w_node[gi+1]),
                    .i_start (w_start[gi+1]),
                    .o_live  (w_live[gi]),
                    .o_match (w_match[gi]),
                    .o_node  (w_node[gi]),
                    .o_start (w_start[gi])
                );
            end
        end
    endgenerate

    // child lookup address for the word entering the first stage
    assign o_rd_node = (i_ctl.a_src == tmpm_pkg::SRC_CELL) ? w_node[0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_live <= 1'b0;
            r_b_live <= 1'b0;
        end else if (i_ctl.clear) begin
            r_a_live <= 1'b0;
            r_b_live <= 1'b0;
        end else if (i_ctl.shift) begin
            unique case (i_ctl.a_src)
                tmpm_pkg::SRC_CELL: r_a_live <= w_live[0];
                tmpm_pkg::SRC_ROOT: r_a_live <= 1'b1;
                default:            r_a_live <= 1'b0;
            endcase
            r_b_live <= r_a_live & i_ctl.letter_ok & (i_child != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_a_start <= (i_ctl.a_src == tmpm_pkg::SRC_ROOT) ? i_pos : w_start[0];
            r_b_node  <= i_child;
            r_b_start <= r_a_start;
        end
    end

    assign o_mark_node  = i_child;
    assign o_head_match = w_live[0] & w_match[0];
    assign o_head_start = w_start[0];

endmodule

// ----- rtl/trie_multi_pattern_matcher.sv -----
// top level of the trie multi-pattern matcher: sequencer, node tables, output register
// depends on tmpm_pkg and tmpm_walk_chain
//
// input channel carries one letter per word: tuser selects dictionary (0) or text (1),
// tlast ends a dictionary word, tdata holds the letter and the first-of-text flag.
// output channel carries results: tuser is the status, tlast the last result of the
// input word, tdata the match start and end positions.
// after reset the child table and word-end marks are swept to zero, one entry a cycle,
// through all NODES*ALPHABET child entries; no input word is taken meanwhile.
// a dictionary letter passes accept, child read and update, plus a result at word end;
// a letter of an already dropped word skips the child read and update.
// a text letter pushes every walk cell through the single child table port and the
// word-end mark port, then sends its matches oldest first when any.
// each result waits in an output register; a stalled receiver holds the sequencer
// only when a new result must be loaded.
module trie_multi_pattern_matcher #(
    parameter int NODES     = tmpm_pkg::NODES_DEF,
    parameter int MAX_DEPTH = tmpm_pkg::MAX_DEPTH_DEF,
    parameter int ALPHABET  = tmpm_pkg::ALPHABET_DEF,
    parameter int POS_BITS  = tmpm_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // letter[4:0], text_first[5], zero[7:6]
    input  logic        i_s_axis_tuser,   // mode
    input  logic        i_s_axis_tlast,   // word_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // match_start[15:0], match_end[31:16]
    output logic [1:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast    // last
);

    localparam int NODE_W = $clog2(NODES);
    localparam int ADDR_W = $clog2(NODES * ALPHABET);
    localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
    localparam int STEP_W = $clog2(MAX_DEPTH + 3);
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);

    tmpm_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0]            r_clr_cnt;
    logic [tmpm_pkg::LETTER_W-1:0] r_letter;
    logic                         r_end;
    logic [NODE_W:0]              r_free;
    logic [NODE_W-1:0]            r_cursor;
    logic [DEP_W-1:0]             r_depth;
    logic                         r_failed;
    logic [POS_BITS-1:0]          r_pos;
    logic [STEP_W-1:0]            r_step;
    logic [CNT_W-1:0]             r_mcount;
    logic [CNT_W-1:0]             r_emitted;

    logic                              r_ov;
    logic [tmpm_pkg::STATUS_W-1:0]     r_ostatus;
    logic [tmpm_pkg::POS_OUT_W-1:0]    r_ostart;
    logic [tmpm_pkg::POS_OUT_W-1:0]    r_oend;
    logic                              r_olast;

    logic [NODE_W-1:0] r_child_mem [NODES * ALPHABET];
    logic              r_mark_mem  [NODES];
    logic [NODE_W-1:0] r_child_rd;
    logic              r_mark_rd;

    tmpm_pkg::t_chain_ctl w_ctl;
    logic [NODE_W-1:0]    w_rd_node;
    logic [NODE_W-1:0]    w_mark_node;
    logic                 w_push_match;
    logic                 w_head_match;
    logic [POS_BITS-1:0]  w_head_start;

    logic              w_accept;
    logic              w_mode;
    logic              w_first;
    logic [tmpm_pkg::LETTER_W-1:0] w_in_letter;
    logic              w_load_ok;
    logic              w_out_free;
    logic              w_letter_ok;
    logic [NODE_W-1:0] w_node_sel;
    logic [ADDR_W-1:0] w_addr;
    logic              w_clr_last;
    logic              w_walk_last;
    logic              w_emit_last;
    logic [CNT_W-1:0]  w_mcount_nxt;
    logic [CNT_W-1:0]  w_limit;
    logic              w_want;
    logic              w_advance;
    logic              w_word_out;
    logic              w_match_out;
    logic              w_child_we;
    logic [ADDR_W-1:0] w_child_waddr;
    logic [NODE_W-1:0] w_child_wdata;
    logic              w_mark_we;
    logic [NODE_W-1:0] w_mark_waddr;
    logic              w_mark_wdata;
    logic              w_new_node;

    assign w_mode      = i_s_axis_tuser;
    assign w_first     = i_s_axis_tdata[5];
    assign w_in_letter = i_s_axis_tdata[4:0];
    assign o_s_axis_tready = (r_state == tmpm_pkg::ST_IDLE);
    assign w_accept    = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_free  = ~r_ov | i_m_axis_tready;

    assign w_load_ok   = ~r_failed && (32'(w_in_letter) < ALPHABET)
                         && (r_depth < DEP_W'(MAX_DEPTH));
    assign w_letter_ok = (32'(r_letter) < ALPHABET);
    assign w_node_sel  = (r_state == tmpm_pkg::ST_WALK) ? w_rd_node : r_cursor;
    assign w_addr      = ADDR_W'(w_node_sel) * ADDR_W'(ALPHABET) + ADDR_W'(r_letter);
    assign w_clr_last  = (r_clr_cnt == ADDR_W'(NODES * ALPHABET - 1));
    assign w_walk_last = (r_step == STEP_W'(MAX_DEPTH + 2));
    assign w_emit_last = (r_step == STEP_W'(MAX_DEPTH - 1));
    assign w_mcount_nxt = r_mcount + CNT_W'(w_push_match);
    assign w_limit     = (32'(r_mcount) > tmpm_pkg::MAX_RESULTS)
                         ? CNT_W'(tmpm_pkg::MAX_RESULTS) : r_mcount;
    assign w_want      = w_head_match && (r_emitted < w_limit);
    assign w_advance   = ~w_want | w_out_free;
    assign w_new_node  = (r_child_rd == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmpm_pkg::ST_CLEAR: begin
                if (w_clr_last) n_state = tmpm_pkg::ST_IDLE;
            end
            tmpm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_mode)              n_state = tmpm_pkg::ST_WALK;
                    else if (w_load_ok)      n_state = tmpm_pkg::ST_LOAD_RD;
                    else if (i_s_axis_tlast) n_state = tmpm_pkg::ST_LOAD_OUT;
                end
            end
            tmpm_pkg::ST_LOAD_RD:  n_state = tmpm_pkg::ST_LOAD_UPD;
            tmpm_pkg::ST_LOAD_UPD: begin
                n_state = r_end ? tmpm_pkg::ST_LOAD_OUT : tmpm_pkg::ST_IDLE;
            end
            tmpm_pkg::ST_LOAD_OUT: begin
                if (w_out_free) n_state = tmpm_pkg::ST_IDLE;
            end
            tmpm_pkg::ST_WALK: begin
                if (w_walk_last) begin
                    n_state = (w_mcount_nxt != '0) ? tmpm_pkg::ST_EMIT : tmpm_pkg::ST_IDLE;
                end
            end
            tmpm_pkg::ST_EMIT: begin
                if (w_advance && w_emit_last) n_state = tmpm_pkg::ST_IDLE;
            end
            default: n_state = tmpm_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ctl.shift     = 1'b0;
        w_ctl.rotate    = 1'b0;
        w_ctl.clear     = 1'b0;
        w_ctl.letter_ok = w_letter_ok;
        w_ctl.a_src     = tmpm_pkg::SRC_DEAD;
        w_word_out      = 1'b0;
        w_match_out     = 1'b0;
        w_child_we      = 1'b0;
        w_child_waddr   = w_addr;
        w_child_wdata   = r_free[NODE_W-1:0];
        w_mark_we       = 1'b0;
        w_mark_waddr    = r_cursor;
        w_mark_wdata    = 1'b1;
        unique case (r_state)
            tmpm_pkg::ST_CLEAR: begin
                w_child_we    = 1'b1;
                w_child_waddr = r_clr_cnt;
                w_child_wdata = '0;
                w_mark_we     = (32'(r_clr_cnt) < NODES);
                w_mark_waddr  = r_clr_cnt[NODE_W-1:0];
                w_mark_wdata  = 1'b0;
            end
            tmpm_pkg::ST_IDLE: begin
                w_ctl.clear = w_accept & w_mode & w_first;
            end
            tmpm_pkg::ST_LOAD_UPD: begin
                w_child_we = w_new_node && (32'(r_free) < NODES);
            end
            tmpm_pkg::ST_LOAD_OUT: begin
                w_word_out = w_out_free;
                w_mark_we  = w_out_free & ~r_failed;
            end
            tmpm_pkg::ST_WALK: begin
                w_ctl.shift = 1'b1;
                if (r_step == '0 || r_step > STEP_W'(MAX_DEPTH))
                    w_ctl.a_src = tmpm_pkg::SRC_DEAD;
                else if (r_step == STEP_W'(MAX_DEPTH))
                    w_ctl.a_src = tmpm_pkg::SRC_ROOT;
                else
                    w_ctl.a_src = tmpm_pkg::SRC_CELL;
            end
            tmpm_pkg::ST_EMIT: begin
                w_ctl.rotate = w_advance;
                w_match_out  = w_want & w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tmpm_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
            r_free    <= (NODE_W+1)'(1);
            r_cursor  <= '0;
            r_depth   <= '0;
            r_failed  <= 1'b0;
            r_pos     <= '0;
            r_step    <= '0;
            r_mcount  <= '0;
            r_emitted <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tmpm_pkg::ST_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;

            if (w_accept) begin
                r_step    <= '0;
                r_mcount  <= '0;
                r_emitted <= '0;
                if (w_mode && w_first) r_pos <= '0;
                if (!w_mode && !w_load_ok) r_failed <= 1'b1;
            end

            if (r_state == tmpm_pkg::ST_LOAD_UPD) begin
                if (!w_new_node) begin
                    r_cursor <= r_child_rd;
                    r_depth  <= r_depth + 1'b1;
                end else if (32'(r_free) < NODES) begin
                    r_cursor <= r_free[NODE_W-1:0];
                    r_depth  <= r_depth + 1'b1;
                    r_free   <= r_free + 1'b1;
                end else begin
                    r_failed <= 1'b1;
                end
            end

            if (w_word_out) begin
                r_cursor <= '0;
                r_depth  <= '0;
                r_failed <= 1'b0;
            end

            if (r_state == tmpm_pkg::ST_WALK) begin
                r_mcount <= w_mcount_nxt;
                r_step   <= w_walk_last ? '0 : r_step + 1'b1;
                if (w_walk_last && w_mcount_nxt == '0) r_pos <= r_pos + 1'b1;
            end

            if (r_state == tmpm_pkg::ST_EMIT && w_advance) begin
                r_step <= r_step + 1'b1;
                if (w_emit_last) r_pos <= r_pos + 1'b1;
            end
            if (w_match_out) r_emitted <= r_emitted + 1'b1;

            if (w_word_out || w_match_out) r_ov <= 1'b1;
            else if (i_m_axis_tready)      r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_letter <= w_in_letter;
            r_end    <= i_s_axis_tlast;
        end
        if (w_word_out) begin
            r_ostatus <= r_failed ? tmpm_pkg::STATUS_DROPPED : tmpm_pkg::STATUS_STORED;
            r_ostart  <= '0;
            r_oend    <= '0;
            r_olast   <= 1'b1;
        end else if (w_match_out) begin
            r_ostatus <= tmpm_pkg::STATUS_MATCH;
            r_ostart  <= tmpm_pkg::POS_OUT_W'(w_head_start);
            r_oend    <= tmpm_pkg::POS_OUT_W'(r_pos);
            r_olast   <= (CNT_W'(r_emitted + 1'b1) == w_limit);
        end
    end

    // child table
    always_ff @(posedge i_clk) begin
        if (w_child_we) r_child_mem[w_child_waddr] <= w_child_wdata;
        r_child_rd <= r_child_mem[w_addr];
    end

    // word-end marks
    always_ff @(posedge i_clk) begin
        if (w_mark_we) r_mark_mem[w_mark_waddr] <= w_mark_wdata;
        r_mark_rd <= r_mark_mem[w_mark_node];
    end

    tmpm_walk_chain #(
        .NODE_W (NODE_W),
        .POS_W  (POS_BITS),
        .DEPTH  (MAX_DEPTH)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_pos        (r_pos),
        .i_child      (r_child_rd),
        .i_mark       (r_mark_rd),
        .o_rd_node    (w_rd_node),
        .o_mark_node  (w_mark_node),
        .o_push_match (w_push_match),
        .o_head_match (w_head_match),
        .o_head_start (w_head_start)
    );

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_oend, r_ostart};
    assign o_m_axis_tuser  = r_ostatus;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ----- rtl/tmpm_checker.sv -----
// port-level checks of the trie multi-pattern matcher, bound to the top level
// depends on tmpm_pkg
module tmpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("outputs active right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled word changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3)
        else $error("undefined status");

    a_word_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != tmpm_pkg::STATUS_MATCH
            |-> o_m_axis_tlast && o_m_axis_tdata == 32'd0)
        else $error("word status result malformed");

endmodule

bind trie_multi_pattern_matcher tmpm_checker u_tmpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
